/* src/smpd_pkg.sv */
// Types and constants shared by the serial mouse packet decoder.
package smpd_pkg;

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned MaxEvents = 3;

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_LEFT   = 2'd1,
    BTN_MIDDLE = 2'd2,
    BTN_RIGHT  = 2'd3
  } button_e;

  typedef struct packed {
    kind_e              kind;
    button_e            button;
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
    logic               last;
  } event_t;

  localparam logic [8:0] OffsetNeg64  = 9'h1c0;
  localparam logic [8:0] OffsetNeg128 = 9'h180;
  localparam logic [8:0] OffsetPos64  = 9'h040;

  function automatic logic signed [8:0] decode_delta(input logic [6:0] data,
                                                      input logic sign_bit,
                                                      input logic ovf_bit);
    logic [8:0] base;
    logic [8:0] offset;
    base = {2'b00, data};
    case ({sign_bit, ovf_bit})
      2'b11:   offset = OffsetNeg64;
      2'b10:   offset = OffsetNeg128;
      2'b01:   offset = OffsetPos64;
      default: offset = 9'h000;
    endcase
    return $signed(base + offset);
  endfunction

endpackage

/* src/serial_mouse_packet_decoder.sv */
// Serial mouse three-byte packet decoder with event output queue.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | to block  | in_valid_i / in_stall_o   | rx_byte_i
//   out     | from block| out_valid_o / out_stall_i | event_kind_o, button_index_o,
//           |           |                           | delta_x_o, delta_y_o, last_of_run_o
//
// A byte is registered on accept and decoded in the next cycle; its events enter
// an 8-entry queue, from which the head event is presented on the output.
// One byte may be accepted every cycle while in_stall_o is low; the queue drains
// one event per cycle while out_stall_i is low and so sets the sustained rate.
// in_stall_o rises when the queue may lack room for a staged and a new byte.
// rst_ni clears the frame state, button levels, init flag and the queue.
module serial_mouse_packet_decoder import smpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_kind_o,
  output logic [1:0]        button_index_o,
  output logic signed [8:0] delta_x_o,
  output logic signed [8:0] delta_y_o,
  output logic              last_of_run_o
);

  localparam logic [1:0] PHASE_HUNT = 2'd0;
  localparam logic [1:0] PHASE_X    = 2'd1;
  localparam logic [1:0] PHASE_Y    = 2'd2;

  localparam logic [CntW-1:0] LimitStaged = CntW'(FifoDepth - 2 * MaxEvents);
  localparam logic [CntW-1:0] LimitIdle   = CntW'(FifoDepth - MaxEvents);

  logic             in_accept;
  logic             in_valid_q;
  logic [7:0]       byte_q;

  logic [1:0]       phase_q, phase_d;
  logic [7:0]       header_q, header_d;
  logic [6:0]       first_q, first_d;
  logic             left_q, left_d;
  logic             middle_q, middle_d;
  logic             right_q, right_d;
  logic             init_q, init_d;

  event_t           cand [MaxEvents];
  logic [2:0]       present;
  event_t           ev [MaxEvents];
  logic [1:0]       push_n;

  event_t           fifo_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             pop;
  event_t           head;

  assign in_stall_o = in_valid_q ? (count_q > LimitStaged) : (count_q > LimitIdle);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Decode the staged byte.
  always_comb begin
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              move;
    logic [1:0]        n;
    phase_d  = phase_q;
    header_d = header_q;
    first_d  = first_q;
    left_d   = left_q;
    middle_d = middle_q;
    right_d  = right_q;
    init_d   = init_q;
    present  = 3'b000;
    dx       = decode_delta(first_q, header_q[1], header_q[0]);
    dy       = decode_delta(byte_q[6:0], header_q[3], header_q[2]);
    move     = (dx != 9'sd0) || (dy != 9'sd0);
    for (int i = 0; i < MaxEvents; i++) begin
      cand[i] = '{kind: KIND_MOVE, button: BTN_NONE, dx: 9'sd0, dy: 9'sd0, last: 1'b0};
    end
    if (in_valid_q) begin
      case (phase_q)
        PHASE_X: begin
          first_d = byte_q[6:0];
          phase_d = PHASE_Y;
        end
        PHASE_Y: begin
          phase_d     = PHASE_HUNT;
          present[0]  = move;
          cand[0].dx  = dx;
          cand[0].dy  = dy;
          if (move) begin
            init_d = 1'b1;
          end
          present[1]     = left_q != header_q[5];
          cand[1].kind   = header_q[5] ? KIND_PRESS : KIND_RELEASE;
          cand[1].button = BTN_LEFT;
          left_d         = header_q[5];
          present[2]     = right_q != header_q[4];
          cand[2].kind   = header_q[4] ? KIND_PRESS : KIND_RELEASE;
          cand[2].button = BTN_RIGHT;
          right_d        = header_q[4];
        end
        default: begin
          if (byte_q[6]) begin
            header_d = byte_q;
            phase_d  = PHASE_X;
          end else if (init_q) begin
            present[0]     = middle_q != byte_q[5];
            cand[0].kind   = byte_q[5] ? KIND_PRESS : KIND_RELEASE;
            cand[0].button = BTN_MIDDLE;
            middle_d       = byte_q[5];
          end
        end
      endcase
    end
    cand[0].last = present[0] && !present[1] && !present[2];
    cand[1].last = present[1] && !present[2];
    cand[2].last = present[2];
    // Pack the present events to the front.
    n = 2'd0;
    for (int i = 0; i < MaxEvents; i++) begin
      ev[i] = cand[i];
    end
    for (int i = 0; i < MaxEvents; i++) begin
      if (present[i]) begin
        ev[n] = cand[i];
        n     = n + 2'd1;
      end
    end
    push_n = n;
  end

  assign head           = fifo_q[rd_ptr_q];
  assign out_valid_o    = count_q != '0;
  assign pop            = out_valid_o && !out_stall_i;
  assign event_kind_o   = head.kind;
  assign button_index_o = head.button;
  assign delta_x_o      = head.dx;
  assign delta_y_o      = head.dy;
  assign last_of_run_o  = head.last;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= rx_byte_i;
    end
    for (int i = 0; i < MaxEvents; i++) begin
      if (2'(i) < push_n) begin
        fifo_q[wr_ptr_q + PtrW'(i)] <= ev[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PHASE_HUNT;
      header_q   <= '0;
      first_q    <= '0;
      left_q     <= 1'b0;
      middle_q   <= 1'b0;
      right_q    <= 1'b0;
      init_q     <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      in_valid_q <= in_accept;
      phase_q    <= phase_d;
      header_q   <= header_d;
      first_q    <= first_d;
      left_q     <= left_d;
      middle_q   <= middle_d;
      right_q    <= right_d;
      init_q     <= init_d;
      wr_ptr_q   <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q   <= rd_ptr_q + PtrW'(pop);
      count_q    <= count_q + CntW'(push_n) - CntW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("event queue overflow");

  a_phase_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("unreachable frame phase");

  a_init_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |=> init_q)
    else $error("init flag cleared");

  a_mid_needs_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_q |=> middle_q == $past(middle_q))
    else $error("middle button changed before init");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> (count_q + CntW'(push_n)) <= CntW'(FifoDepth))
    else $error("push without room");

endmodule

/* tb/tb_serial_mouse_packet_decoder.sv */
// Self-checking testbench for the serial mouse packet decoder.
`timescale 1ns / 1ps

module tb_serial_mouse_packet_decoder;
  import smpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } frame_phase_e;

  typedef struct {
    kind_e             kind;
    button_e           button;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              last;
  } mouse_event_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        event_kind_o;
  logic [1:0]        button_index_o;
  logic signed [8:0] delta_x_o;
  logic signed [8:0] delta_y_o;
  logic              last_of_run_o;

  mouse_event_t pending_events[$];
  int           error_count = 0;
  int           send_idle_pct = 9;
  int           recv_stall_pct = 80;

  frame_phase_e frame_phase = PH_HUNT;
  logic [7:0]   hdr_latch = 8'h00;
  logic [6:0]   x_bits = 7'h00;
  logic         left_held = 1'b0;
  logic         middle_held = 1'b0;
  logic         right_held = 1'b0;
  logic         mouse_ready = 1'b0;

  serial_mouse_packet_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .button_index_o (button_index_o),
    .delta_x_o      (delta_x_o),
    .delta_y_o      (delta_y_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("tb_serial_mouse_packet_decoder: errors");
    $finish;
  end

  function automatic logic signed [8:0] frame_delta(input logic [6:0] d, input logic neg,
                                                    input logic ovf);
    int v;
    v = int'(d);
    if (neg) begin
      v = ovf ? v - 64 : v - 128;
    end else if (ovf) begin
      v = v + 64;
    end
    return v[8:0];
  endfunction

  function automatic int button_edge(inout logic held, input logic level, input button_e btn);
    if (held == level) return 0;
    held = level;
    pending_events.push_back('{level ? KIND_PRESS : KIND_RELEASE, btn, 9'sd0, 9'sd0, 1'b0});
    return 1;
  endfunction

  task automatic decode_mouse_byte(input logic [7:0] b);
    int                n;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    n = 0;
    case (frame_phase)
      PH_X: begin
        x_bits = b[6:0];
        frame_phase = PH_Y;
      end
      PH_Y: begin
        dx = frame_delta(x_bits, hdr_latch[1], hdr_latch[0]);
        dy = frame_delta(b[6:0], hdr_latch[3], hdr_latch[2]);
        frame_phase = PH_HUNT;
        if (dx != 0 || dy != 0) begin
          pending_events.push_back('{KIND_MOVE, BTN_NONE, dx, dy, 1'b0});
          mouse_ready = 1'b1;
          n++;
        end
        n += button_edge(left_held, hdr_latch[5], BTN_LEFT);
        n += button_edge(right_held, hdr_latch[4], BTN_RIGHT);
      end
      default: begin
        if (b[6]) begin
          hdr_latch = b;
          frame_phase = PH_X;
        end else if (mouse_ready) begin
          n += button_edge(middle_held, b[5], BTN_MIDDLE);
        end
      end
    endcase
    if (n > 0) pending_events[pending_events.size() - 1].last = 1'b1;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_events
    mouse_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected item: kind %0d btn %0d dx %0d dy %0d last %0b",
                   event_kind_o, button_index_o, delta_x_o, delta_y_o, last_of_run_o);
        end
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.kind || button_index_o !== want.button ||
            delta_x_o !== want.dx || delta_y_o !== want.dy || last_of_run_o !== want.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: got kind %0d btn %0d dx %0d dy %0d last %0b",
                     event_kind_o, button_index_o, delta_x_o, delta_y_o, last_of_run_o);
            $display("     expected kind %0d btn %0d dx %0d dy %0d last %0b",
                     want.kind, want.button, want.dx, want.dy, want.last);
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_mouse_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  task automatic test_ignored_until_init();
    send_byte(8'h20);
    send_byte(8'hbf);
    send_frame(8'h40, 8'h00, 8'h00);
    send_frame(8'h60, 8'h80, 8'h80);
  endtask

  task automatic test_delta_extremes();
    send_frame(8'h52, 8'h00, 8'h7f);
    send_frame(8'h45, 8'hff, 8'hff);
    send_frame(8'h4a, 8'h80, 8'h00);
    send_frame(8'h4f, 8'h40, 8'h40);
    send_frame(8'hff, 8'h01, 8'h02);
  endtask

  task automatic test_middle_button();
    send_byte(8'h20);
    send_byte(8'h20);
    send_byte(8'h00);
    send_byte(8'ha0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int         sent;
    int         pick;
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        hdr = 8'($urandom_range(255));
        xb  = 8'($urandom_range(255));
        yb  = 8'($urandom_range(255));
        hdr[6] = 1'b1;
        if (pick < 6) begin
          hdr[3:0] = 4'h0;
          xb[6:0]  = 7'h00;
          yb[6:0]  = 7'h00;
        end else if (pick < 12) begin
          hdr[3:0] = 4'hf;
          xb[6:0]  = 7'h40;
          yb[6:0]  = 7'h40;
        end
        send_frame(hdr, xb, yb);
        sent += 3;
      end else if (pick < 93) begin
        hdr = 8'($urandom_range(255));
        hdr[6] = 1'b0;
        send_byte(hdr);
        sent++;
      end else begin
        send_byte(8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_ignored_until_init();
    test_delta_extremes();
    test_middle_button();
    test_random_traffic(148);
    send_idle_pct  = 80;
    recv_stall_pct = 9;
    test_random_traffic(148);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(148);
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_events.size() == 0) begin
      $display("tb_serial_mouse_packet_decoder: clean");
    end else begin
      $display("tb_serial_mouse_packet_decoder: errors");
    end
    $finish;
  end

endmodule
